>>> rtl/scan_grid_raycaster_unit_macros.svh
// Assertion macros for the scan grid raycaster
`ifndef SCAN_GRID_RAYCASTER_UNIT_MACROS_SVH
`define SCAN_GRID_RAYCASTER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SGR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SGR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sgr_pkg.sv
// Package: payload types, sequencer states, register indexes and sine table
`timescale 1ns / 1ps
package sgr_pkg;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        heading;
        logic [15:0]        start_angle;
        logic signed [15:0] angle_step;
        logic [15:0]        range;
        logic               last_beam;
    } sgr_in_t;

    typedef struct packed {
        logic [15:0] virtual_range;
        logic        last_of_scan;
    } sgr_out_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CMP,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_MK_SLOT,
        ST_MK_RD,
        ST_MK_COS,
        ST_MK_PX,
        ST_MK_PY,
        ST_MK_WR,
        ST_Q_COS,
        ST_Q_SIN,
        ST_Q_PX,
        ST_Q_PY,
        ST_Q_RD,
        ST_Q_CHK,
        ST_Q_OUT
    } sgr_state_t;

    localparam logic [1:0] CFG_SCAN_COUNT     = 2'd0;
    localparam logic [1:0] CFG_MAX_RANGE      = 2'd1;
    localparam logic [1:0] CFG_DIFF_THRESHOLD = 2'd2;

    localparam logic       MODE_SCAN  = 1'b0;
    localparam logic       MODE_QUERY = 1'b1;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    localparam logic [14:0] SINE_Q14 [0:64] = '{
        15'd0, 15'd402, 15'd804, 15'd1205, 15'd1606, 15'd2006, 15'd2404, 15'd2801,
        15'd3196, 15'd3590, 15'd3981, 15'd4370, 15'd4756, 15'd5139, 15'd5520,
        15'd5897, 15'd6270, 15'd6639, 15'd7005, 15'd7366, 15'd7723, 15'd8076,
        15'd8423, 15'd8765, 15'd9102, 15'd9434, 15'd9760, 15'd10080, 15'd10394,
        15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
        15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623,
        15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811,
        15'd14978, 15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679,
        15'd15791, 15'd15893, 15'd15986, 15'd16069, 15'd16143, 15'd16207,
        15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379, 15'd16384
    };

    function automatic logic signed [15:0] fx_sin(input logic [15:0] a);
        logic [14:0] q;
        logic [6:0]  i;
        logic [7:0]  f;
        logic [14:0] b0;
        logic [14:0] b1;
        logic [17:0] acc;
        logic [14:0] v;
        q = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        i = q[14:8];
        f = q[7:0];
        b0 = 15'd0;
        b1 = 15'd0;
        acc = 18'd0;
        if (i >= 7'd64)
        begin
            v = SINE_Q14[64];
        end
        else
        begin
            b0 = SINE_Q14[i];
            b1 = SINE_Q14[i + 7'd1];
            acc = ({3'b0, b1} - {3'b0, b0}) * {10'b0, f} + 18'd128;
            v = b0 + 15'(acc >> 8);
        end
        return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

>>> rtl/scan_grid_raycaster_unit.sv
// Scan grid raycaster: scan ring, occupancy grid rebuild and virtual beam ray casting
// Kept last beam: staged beams copied into the ring, grid cleared, then each stored scan
// redrawn beam by beam, skipping beams at or past max_range; one shared sine/project path.
// Query: ray setup, then half-cell steps up to max_range (max_range when none hits), then
// emit; ready only when idle. Reset: asynchronous, active low; then a grid clearing pass
// over 4^clog2(GRID_CELLS) cells (65536 at defaults), in_ready low. Config writes any time.
`timescale 1ns / 1ps
module scan_grid_raycaster_unit #(
    parameter int GRID_CELLS     = 256,
    parameter int SCANS          = 8,
    parameter int BEAMS          = 256,
    parameter int CELL_FRAC_BITS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sgr_pkg::sgr_in_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sgr_pkg::sgr_out_t out_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import sgr_pkg::*;

`include "scan_grid_raycaster_unit_macros.svh"

    localparam int GW  = $clog2(GRID_CELLS);
    localparam int GA  = 2 * GW;
    localparam int HW  = (SCANS > 1) ? $clog2(SCANS) : 1;
    localparam int NW  = $clog2(SCANS + 1);
    localparam int BIW = $clog2(BEAMS);
    localparam int BCW = $clog2(BEAMS + 1);
    localparam int RAW = HW + BIW;
    localparam int TW  = 24;
    localparam int RW  = 17;
    localparam logic signed [TW-1:0] OFFSET = TW'((GRID_CELLS / 2) << CELL_FRAC_BITS);
    localparam logic [TW-1:0] HALF = TW'(1 << (CELL_FRAC_BITS - 1));
    localparam logic [RW-1:0] STEP = RW'(1 << (CELL_FRAC_BITS - 1));

    function automatic logic signed [TW-1:0] proj(input logic [RW-1:0] r,
                                                  input logic signed [15:0] c);
        logic [14:0] mag;
        logic [32:0] p;
        logic [TW-1:0] m;
        mag = c[15] ? 15'(-c) : 15'(c);
        p = 33'(r) * 33'(mag) + 33'd8192;
        m = TW'(p >> 14);
        return c[15] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [GW:0] to_cell(input logic signed [TW-1:0] t);
        logic signed [TW-1:0] tt;
        logic [TW-1:0] mag;
        logic [TW-1:0] m;
        logic ok;
        tt = t + OFFSET;
        mag = tt[TW-1] ? TW'(-tt) : TW'(tt);
        m = (mag + HALF) >> CELL_FRAC_BITS;
        ok = tt[TW-1] ? (m == '0) : (m < TW'(GRID_CELLS));
        return {ok, m[GW-1:0]};
    endfunction

    sgr_state_t state_reg, state_next;
    logic [GA-1:0] clear_addr_reg, clear_addr_next;
    logic build_reg, build_next;
    logic [3:0] sc_reg;
    logic [15:0] maxr_reg, thr_reg;
    sgr_in_t item_reg, item_next;
    logic run_mode_reg, run_mode_next;
    logic [15:0] beam_index_reg, beam_index_next;
    logic differs_reg, differs_next;
    logic [HW-1:0] head_reg, head_next;
    logic [NW-1:0] held_reg, held_next;
    logic [BCW-1:0] total_reg, total_next;
    logic [15:0] newest_heading_reg, newest_heading_next;
    logic signed [15:0] newest_x_reg, newest_x_next, newest_y_reg, newest_y_next;
    logic signed [15:0] pose_x_reg [SCANS];
    logic signed [15:0] pose_y_reg [SCANS];
    logic [15:0] base_reg [SCANS];
    logic [15:0] step_reg [SCANS];
    logic pose_we;
    logic cmp_en_reg, cmp_en_next;
    logic [BCW-1:0] copy_idx_reg, copy_idx_next;
    logic [NW-1:0] k_reg, k_next;
    logic [BCW-1:0] j_reg, j_next;
    logic [HW-1:0] slot_reg, slot_next;
    logic [15:0] step_cur_reg, step_cur_next;
    logic signed [16:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [15:0] ang_reg, ang_next;
    logic [RW-1:0] r_reg, r_next;
    logic signed [15:0] cos_reg, cos_next, sin_reg, sin_next;
    logic signed [TW-1:0] px_reg, px_next, py_reg, py_next;
    logic qin_reg, qin_next;
    logic [15:0] ans_reg, ans_next;
    logic out_valid_reg, out_valid_next;
    sgr_out_t out_reg, out_next;

    logic [15:0] stg_mem [BEAMS];
    logic [15:0] rng_mem [2**RAW];
    logic grid_mem [2**GA];
    logic [15:0] stg_rdata, rng_rdata;
    logic grid_rdata;

    logic stg_we, rng_we, grid_we, grid_wdata, proj_sel;
    logic [BIW-1:0] stg_waddr, stg_raddr;
    logic [RAW-1:0] rng_waddr, rng_raddr;
    logic [GA-1:0] grid_waddr, grid_raddr;
    logic [15:0] sin_arg;
    logic signed [15:0] sin_out;
    logic signed [TW-1:0] proj_out;
    logic [GW:0] cell_x, cell_y;
    logic cell_ok;

    logic accept, new_run, dif_eff, dif_new, skip_keep, count_same, mk_skip, j_more;
    logic [15:0] bidx_eff, diff_abs;
    logic [BCW-1:0] count;
    logic [NW-1:0] cap, held_base;
    logic [NW:0] held_inc;
    logic [HW-1:0] slot_c;
    int cap_i, slot_i;

    assign accept = in_valid && in_ready;
    assign new_run = in_data.mode != run_mode_reg;
    assign bidx_eff = new_run ? 16'd0 : beam_index_reg;
    assign dif_eff = new_run ? 1'b0 : differs_reg;
    assign diff_abs = (item_reg.range > rng_rdata) ? (item_reg.range - rng_rdata)
                                                   : (rng_rdata - item_reg.range);
    assign dif_new = differs_reg || (cmp_en_reg && (diff_abs > thr_reg));
    assign count = beam_index_reg[BCW-1:0];
    assign count_same = count == total_reg;
    assign skip_keep = (held_reg != '0) && !dif_new && count_same;
    assign mk_skip = rng_rdata >= maxr_reg;
    assign j_more = (j_reg + 1'b1) < total_reg;

    always_comb
    begin
        cap_i = (sc_reg == 4'd0) ? 1 : ((int'(sc_reg) > SCANS) ? SCANS : int'(sc_reg));
        slot_i = (int'(head_reg) >= int'(k_reg)) ? (int'(head_reg) - int'(k_reg))
                                                : (int'(head_reg) + SCANS - int'(k_reg));
    end
    assign cap = NW'(cap_i);
    assign slot_c = HW'(slot_i);
    assign held_base = count_same ? held_reg : '0;
    assign held_inc = {1'b0, held_base} + 1'b1;

    assign sin_out = fx_sin(sin_arg);
    assign proj_out = proj(r_reg, proj_sel ? sin_reg : cos_reg);
    assign cell_x = to_cell(px_reg + TW'(rx_reg));
    assign cell_y = to_cell(py_reg + TW'(ry_reg));
    assign cell_ok = cell_x[GW] && cell_y[GW];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_addr_reg == '1)
                    state_next = build_reg ? ST_MK_SLOT : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = (in_data.mode == MODE_QUERY) ? ST_Q_COS : ST_CMP;
            end
            ST_CMP:
            begin
                if (item_reg.last_beam && !skip_keep)
                    state_next = ST_COPY_RD;
                else
                    state_next = ST_IDLE;
            end
            ST_COPY_RD: state_next = ST_COPY_WR;
            ST_COPY_WR:
            begin
                if (copy_idx_reg == BCW'(BEAMS - 1))
                    state_next = ST_CLEAR;
                else
                    state_next = ST_COPY_RD;
            end
            ST_MK_SLOT:
            begin
                if (k_reg == held_reg)
                    state_next = ST_IDLE;
                else if (total_reg != '0)
                    state_next = ST_MK_RD;
            end
            ST_MK_RD: state_next = ST_MK_COS;
            ST_MK_COS:
            begin
                if (mk_skip)
                    state_next = j_more ? ST_MK_RD : ST_MK_SLOT;
                else
                    state_next = ST_MK_PX;
            end
            ST_MK_PX: state_next = ST_MK_PY;
            ST_MK_PY: state_next = ST_MK_WR;
            ST_MK_WR: state_next = j_more ? ST_MK_RD : ST_MK_SLOT;
            ST_Q_COS: state_next = ST_Q_SIN;
            ST_Q_SIN: state_next = ST_Q_PX;
            ST_Q_PX: state_next = (r_reg > {1'b0, maxr_reg}) ? ST_Q_OUT : ST_Q_PY;
            ST_Q_PY: state_next = ST_Q_RD;
            ST_Q_RD: state_next = ST_Q_CHK;
            ST_Q_CHK: state_next = (qin_reg && grid_rdata) ? ST_Q_OUT : ST_Q_PX;
            ST_Q_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = state_reg == ST_IDLE;
        stg_we = accept && (in_data.mode == MODE_SCAN) && (bidx_eff < 16'(BEAMS));
        stg_waddr = bidx_eff[BIW-1:0];
        stg_raddr = copy_idx_reg[BIW-1:0];
        rng_we = state_reg == ST_COPY_WR;
        rng_waddr = {head_reg, copy_idx_reg[BIW-1:0]};
        rng_raddr = (state_reg == ST_IDLE) ? {head_reg, bidx_eff[BIW-1:0]}
                                           : {slot_reg, j_reg[BIW-1:0]};
        grid_we = 1'b0;
        grid_wdata = 1'b0;
        grid_waddr = clear_addr_reg;
        grid_raddr = {cell_y[GW-1:0], cell_x[GW-1:0]};
        sin_arg = ang_reg;
        proj_sel = 1'b0;
        pose_we = (state_reg == ST_CMP) && item_reg.last_beam && !skip_keep;
        case (state_reg)
            ST_CLEAR: grid_we = 1'b1;
            ST_MK_WR:
            begin
                grid_we = cell_ok;
                grid_wdata = 1'b1;
                grid_waddr = {cell_y[GW-1:0], cell_x[GW-1:0]};
            end
            ST_MK_COS: sin_arg = ang_reg + QUARTER_TURN;
            ST_Q_COS:  sin_arg = ang_reg + QUARTER_TURN;
            ST_MK_PY:  proj_sel = 1'b1;
            ST_Q_PY:   proj_sel = 1'b1;
            default:   sin_arg = ang_reg;
        endcase
    end

    // datapath
    always_comb
    begin
        clear_addr_next = clear_addr_reg;
        build_next = build_reg;
        item_next = item_reg;
        run_mode_next = run_mode_reg;
        beam_index_next = beam_index_reg;
        differs_next = differs_reg;
        head_next = head_reg;
        held_next = held_reg;
        total_next = total_reg;
        newest_heading_next = newest_heading_reg;
        newest_x_next = newest_x_reg;
        newest_y_next = newest_y_reg;
        cmp_en_next = cmp_en_reg;
        copy_idx_next = copy_idx_reg;
        k_next = k_reg;
        j_next = j_reg;
        slot_next = slot_reg;
        step_cur_next = step_cur_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        ang_next = ang_reg;
        r_next = r_reg;
        cos_next = cos_reg;
        sin_next = sin_reg;
        px_next = px_reg;
        py_next = py_reg;
        qin_next = qin_reg;
        ans_next = ans_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next = out_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == '1)
                begin
                    build_next = 1'b0;
                    k_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    run_mode_next = in_data.mode;
                    differs_next = dif_eff;
                    if (in_data.mode == MODE_SCAN)
                    begin
                        if (bidx_eff < 16'(BEAMS))
                        begin
                            beam_index_next = bidx_eff + 16'd1;
                            cmp_en_next = (held_reg != '0)
                                && (bidx_eff < {{(16 - BCW){1'b0}}, total_reg});
                        end
                        else
                        begin
                            beam_index_next = bidx_eff;
                            cmp_en_next = 1'b0;
                        end
                    end
                    else
                    begin
                        ang_next = newest_heading_reg + in_data.start_angle
                            + 16'(bidx_eff * in_data.angle_step);
                        beam_index_next = in_data.last_beam ? 16'd0 : bidx_eff + 16'd1;
                        rx_next = '0;
                        ry_next = '0;
                        r_next = '0;
                    end
                end
            end
            ST_CMP:
            begin
                differs_next = dif_new;
                if (item_reg.last_beam)
                begin
                    beam_index_next = 16'd0;
                    differs_next = 1'b0;
                    if (!skip_keep)
                    begin
                        held_next = (held_inc > {1'b0, cap}) ? cap : held_inc[NW-1:0];
                        head_next = (head_reg == HW'(SCANS - 1)) ? '0 : head_reg + 1'b1;
                        newest_heading_next = item_reg.heading;
                        newest_x_next = item_reg.pos_x;
                        newest_y_next = item_reg.pos_y;
                        total_next = count;
                        copy_idx_next = '0;
                    end
                end
            end
            ST_COPY_WR:
            begin
                copy_idx_next = copy_idx_reg + 1'b1;
                if (copy_idx_reg == BCW'(BEAMS - 1))
                begin
                    build_next = 1'b1;
                    clear_addr_next = '0;
                end
            end
            ST_MK_SLOT:
            begin
                if (k_reg != held_reg)
                begin
                    slot_next = slot_c;
                    rx_next = {pose_x_reg[slot_c][15], pose_x_reg[slot_c]}
                        - {newest_x_reg[15], newest_x_reg};
                    ry_next = {pose_y_reg[slot_c][15], pose_y_reg[slot_c]}
                        - {newest_y_reg[15], newest_y_reg};
                    ang_next = base_reg[slot_c];
                    step_cur_next = step_reg[slot_c];
                    j_next = '0;
                    if (total_reg == '0)
                        k_next = k_reg + 1'b1;
                end
            end
            ST_MK_COS:
            begin
                r_next = {1'b0, rng_rdata};
                cos_next = sin_out;
                if (mk_skip)
                begin
                    if (j_more)
                    begin
                        j_next = j_reg + 1'b1;
                        ang_next = ang_reg + step_cur_reg;
                    end
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            ST_MK_PX:
            begin
                px_next = proj_out;
                sin_next = sin_out;
            end
            ST_MK_PY: py_next = proj_out;
            ST_MK_WR:
            begin
                if (j_more)
                begin
                    j_next = j_reg + 1'b1;
                    ang_next = ang_reg + step_cur_reg;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            ST_Q_COS: cos_next = sin_out;
            ST_Q_SIN: sin_next = sin_out;
            ST_Q_PX:
            begin
                if (r_reg > {1'b0, maxr_reg})
                    ans_next = maxr_reg;
                else
                    px_next = proj_out;
            end
            ST_Q_PY: py_next = proj_out;
            ST_Q_RD: qin_next = cell_ok;
            ST_Q_CHK:
            begin
                if (qin_reg && grid_rdata)
                    ans_next = r_reg[15:0];
                else
                    r_next = r_reg + STEP;
            end
            ST_Q_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next.virtual_range = ans_reg;
                    out_next.last_of_scan = item_reg.last_beam;
                end
            end
            default: out_valid_next = out_valid_reg && !out_ready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clear_addr_reg <= '0;
            build_reg <= 1'b0;
            run_mode_reg <= MODE_SCAN;
            beam_index_reg <= '0;
            differs_reg <= 1'b0;
            head_reg <= '0;
            held_reg <= '0;
            total_reg <= '0;
            newest_heading_reg <= '0;
            k_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clear_addr_reg <= clear_addr_next;
            build_reg <= build_next;
            run_mode_reg <= run_mode_next;
            beam_index_reg <= beam_index_next;
            differs_reg <= differs_next;
            head_reg <= head_next;
            held_reg <= held_next;
            total_reg <= total_next;
            newest_heading_reg <= newest_heading_next;
            k_reg <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= 4'd8;
            maxr_reg <= 16'd16384;
            thr_reg <= 16'd26;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCAN_COUNT:     sc_reg <= cfg_data[3:0];
                CFG_MAX_RANGE:      maxr_reg <= cfg_data;
                CFG_DIFF_THRESHOLD: thr_reg <= cfg_data;
                default:            sc_reg <= sc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        newest_x_reg <= newest_x_next;
        newest_y_reg <= newest_y_next;
        cmp_en_reg <= cmp_en_next;
        copy_idx_reg <= copy_idx_next;
        j_reg <= j_next;
        slot_reg <= slot_next;
        step_cur_reg <= step_cur_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        ang_reg <= ang_next;
        r_reg <= r_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
        px_reg <= px_next;
        py_reg <= py_next;
        qin_reg <= qin_next;
        ans_reg <= ans_next;
        out_reg <= out_next;
        if (pose_we)
        begin
            pose_x_reg[head_next] <= item_reg.pos_x;
            pose_y_reg[head_next] <= item_reg.pos_y;
            base_reg[head_next] <= item_reg.heading + item_reg.start_angle;
            step_reg[head_next] <= item_reg.angle_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_we)
            stg_mem[stg_waddr] <= in_data.range;
        stg_rdata <= stg_mem[stg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rng_we)
            rng_mem[rng_waddr] <= stg_rdata;
        rng_rdata <= rng_mem[rng_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_waddr] <= grid_wdata;
        grid_rdata <= grid_mem[grid_raddr];
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    `SGR_ASSERT_IMP(a_held_bound, 1'b1, held_reg <= NW'(SCANS), "held scans above ring depth")
    `SGR_ASSERT_IMP(a_out_from_query, $rose(out_valid_reg), $past(state_reg == ST_Q_OUT),
                    "result raised outside query output step")
    `SGR_ASSERT_NXT(a_query_start, accept && (in_data.mode == MODE_QUERY),
                    state_reg == ST_Q_COS, "query transfer did not start ray setup")
    `SGR_ASSERT_NXT(a_scan_start, accept && (in_data.mode == MODE_SCAN),
                    state_reg == ST_CMP, "scan transfer did not go to compare")

endmodule

>>> test/scan_grid_raycaster_unit_tb.sv
// Testbench for the scan grid raycaster: scoreboard-checked scans, rebuilds and ray queries
`timescale 1ns / 1ps
module scan_grid_raycaster_unit_tb;
    import sgr_pkg::*;

    class ray_scoreboard;
        int unsigned    keep_cap;
        int unsigned    ray_limit;
        int unsigned    threshold;
        bit             occupied [65536];
        bit [15:0]      ring_ranges [8][256];
        int             ring_x [8];
        int             ring_y [8];
        bit [15:0]      ring_base [8];
        bit [15:0]      ring_step [8];
        bit [15:0]      staged [256];
        int unsigned    head;
        int unsigned    held;
        int unsigned    beam_idx;
        int unsigned    beam_count;
        bit             run_mode;
        bit [15:0]      last_heading;
        bit             changed;
        sgr_out_t       expected_ranges [$];
        int             errors;
        int             kept;
        int             checked;

        function new();
            keep_cap = 8;
            ray_limit = 16384;
            threshold = 26;
            head = 0;
            held = 0;
            beam_idx = 0;
            beam_count = 0;
            run_mode = MODE_SCAN;
            last_heading = 0;
            changed = 0;
            errors = 0;
            kept = 0;
            checked = 0;
            foreach (occupied[i]) occupied[i] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == CFG_SCAN_COUNT) keep_cap = val[3:0];
            else if (idx == CFG_MAX_RANGE) ray_limit = val;
            else if (idx == CFG_DIFF_THRESHOLD) threshold = val;
        endfunction

        function int sine(bit [15:0] a);
            int unsigned p;
            int unsigned q;
            int unsigned i;
            int unsigned f;
            int v;
            p = a[13:0];
            q = a[14] ? 16384 - p : p;
            i = q >> 8;
            f = q & 255;
            if (i >= 64) v = SINE_Q14[64];
            else v = SINE_Q14[i] + (((SINE_Q14[i + 1] - SINE_Q14[i]) * f + 128) >> 8);
            return a[15] ? -v : v;
        endfunction

        function int cosine(bit [15:0] a);
            return sine(a + QUARTER_TURN);
        endfunction

        function longint scale(longint r, int c);
            longint m;
            m = r * (c < 0 ? -c : c);
            m = (m + 8192) >>> 14;
            return c < 0 ? -m : m;
        endfunction

        function longint cell_of(longint t);
            longint mag;
            t = t + 128 * 256;
            mag = t < 0 ? -t : t;
            mag = (mag + 128) >>> 8;
            return t < 0 ? -mag : mag;
        endfunction

        function bit locate(longint x, longint y, output int unsigned id);
            longint cx;
            longint cy;
            cx = cell_of(x);
            cy = cell_of(y);
            id = 0;
            if (cx < 0 || cx >= 256 || cy < 0 || cy >= 256) return 0;
            id = cy * 256 + cx;
            return 1;
        endfunction

        function void redraw();
            int unsigned slot;
            int unsigned id;
            longint dx;
            longint dy;
            bit [15:0] a;
            int unsigned r;
            foreach (occupied[i]) occupied[i] = 0;
            for (int unsigned k = 0; k < held; k++)
            begin
                slot = (head + 8 - k) % 8;
                dx = longint'(ring_x[slot]) - ring_x[head];
                dy = longint'(ring_y[slot]) - ring_y[head];
                for (int unsigned j = 0; j < beam_count; j++)
                begin
                    r = ring_ranges[slot][j];
                    a = ring_base[slot] + 16'(j * ring_step[slot]);
                    if (r >= ray_limit) continue;
                    if (locate(scale(r, cosine(a)) + dx, scale(r, sine(a)) + dy, id))
                        occupied[id] = 1;
                end
            end
        endfunction

        function void close_scan(sgr_in_t it);
            int unsigned cap;
            cap = keep_cap == 0 ? 1 : (keep_cap > 8 ? 8 : keep_cap);
            if (held > 0 && !changed && beam_idx == beam_count) return;
            if (beam_idx != beam_count) held = 0;
            head = (head + 1) % 8;
            for (int j = 0; j < 256; j++) ring_ranges[head][j] = staged[j];
            ring_x[head] = it.pos_x;
            ring_y[head] = it.pos_y;
            ring_base[head] = it.heading + it.start_angle;
            ring_step[head] = it.angle_step;
            last_heading = it.heading;
            beam_count = beam_idx;
            held = held + 1 > cap ? cap : held + 1;
            kept++;
            redraw();
        endfunction

        function void note_input(sgr_in_t it);
            int unsigned d;
            int unsigned old;
            bit [15:0] a;
            int c;
            int s;
            int unsigned id;
            sgr_out_t res;
            if (it.mode != run_mode)
            begin
                beam_idx = 0;
                changed = 0;
                run_mode = it.mode;
            end
            if (it.mode == MODE_SCAN)
            begin
                if (beam_idx < 256)
                begin
                    staged[beam_idx] = it.range;
                    if (held > 0 && beam_idx < beam_count)
                    begin
                        old = ring_ranges[head][beam_idx];
                        d = it.range > old ? it.range - old : old - it.range;
                        if (d > threshold) changed = 1;
                    end
                    beam_idx++;
                end
                if (it.last_beam)
                begin
                    close_scan(it);
                    beam_idx = 0;
                    changed = 0;
                end
            end
            else
            begin
                a = last_heading + it.start_angle + 16'(beam_idx * it.angle_step);
                c = cosine(a);
                s = sine(a);
                res.virtual_range = 16'(ray_limit);
                res.last_of_scan = it.last_beam;
                for (longint r = 0; r <= ray_limit; r += 128)
                begin
                    if (locate(scale(r, c), scale(r, s), id) && occupied[id])
                    begin
                        res.virtual_range = 16'(r);
                        break;
                    end
                end
                expected_ranges = {expected_ranges, res};
                beam_idx = it.last_beam ? 0 : ((beam_idx + 1) & 16'hFFFF);
            end
        endfunction

        function void check(sgr_out_t got);
            sgr_out_t want;
            checked++;
            if (expected_ranges.size() == 0)
            begin
                $error("unexpected result range=%0d last=%0d", got.virtual_range,
                       got.last_of_scan);
                errors++;
                return;
            end
            want = expected_ranges[0];
            expected_ranges.delete(0);
            if (got.virtual_range !== want.virtual_range)
            begin
                $error("virtual_range expected %0d actual %0d", want.virtual_range,
                       got.virtual_range);
                errors++;
            end
            if (got.last_of_scan !== want.last_of_scan)
            begin
                $error("last_of_scan expected %0d actual %0d", want.last_of_scan,
                       got.last_of_scan);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    sgr_in_t    in_data;
    logic       out_valid;
    logic       out_ready;
    sgr_out_t   out_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    ray_scoreboard sb;
    bit          quiet;
    int          sent;
    int          stall_left;

    scan_grid_raycaster_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 0;
    always #2 clk = ~clk;

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 14);
    endfunction

    task automatic send_item(sgr_in_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_input(it);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_ranges.size() > 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(int cap, int lim, int thr);
        wait_drained();
        write_reg(CFG_SCAN_COUNT, 16'(cap));
        write_reg(CFG_MAX_RANGE, 16'(lim));
        write_reg(CFG_DIFF_THRESHOLD, 16'(thr));
        cfg_we <= 1'b0;
    endtask

    function automatic sgr_in_t noise_item();
        sgr_in_t it;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(sgr_in_t)-1:0];
        return it;
    endfunction

    task automatic send_beam(bit fin, logic [15:0] r, logic signed [15:0] px,
                             logic signed [15:0] py, logic [15:0] hd, logic [15:0] sa,
                             logic signed [15:0] st);
        sgr_in_t it;
        it = noise_item();
        it.mode = MODE_SCAN;
        it.range = r;
        it.last_beam = fin;
        if (fin)
        begin
            it.pos_x = px;
            it.pos_y = py;
            it.heading = hd;
            it.start_angle = sa;
            it.angle_step = st;
        end
        send_item(it);
    endtask

    task automatic send_query(bit fin, logic [15:0] sa, logic signed [15:0] st);
        sgr_in_t it;
        it = noise_item();
        it.mode = MODE_QUERY;
        it.start_angle = sa;
        it.angle_step = st;
        it.last_beam = fin;
        send_item(it);
    endtask

    function automatic logic [15:0] beam_len();
        int lim;
        lim = sb.ray_limit;
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, lim + lim / 8 > 65535 ? 65535 : lim + lim / 8));
    endfunction

    task automatic random_scan(bit fresh);
        int n;
        int dv;
        int lo;
        logic [15:0] r;
        if (fresh || sb.held == 0) n = $urandom_range(2, 8);
        else n = sb.beam_count;
        for (int j = 0; j < n; j++)
        begin
            if (fresh || sb.held == 0)
                r = beam_len();
            else
            begin
                lo = sb.threshold > 1000 ? 1000 : sb.threshold;
                dv = int'(sb.ring_ranges[sb.head][j]) + $urandom_range(0, 2 * lo) - lo;
                r = dv < 0 ? 16'd0 : (dv > 65535 ? 16'hFFFF : 16'(dv));
            end
            send_beam(j == n - 1, r, 16'($urandom_range(0, 4000) - 2000),
                      16'($urandom_range(0, 4000) - 2000), 16'($urandom),
                      16'($urandom), 16'($urandom));
        end
    endtask

    task automatic random_phase(int count);
        int pick;
        int n;
        int stop;
        stop = sent + count;
        while (sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                n = $urandom_range(1, 4);
                for (int j = 0; j < n; j++)
                    send_query(j == n - 1 || $urandom_range(0, 3) == 0, 16'($urandom),
                               16'($urandom));
            end
            else if (pick < 85)
                random_scan(sb.kept < 14 && $urandom_range(0, 3) == 0);
            else if (pick < 95)
            begin
                n = $urandom_range(1, 3);
                for (int j = 0; j < n; j++)
                    send_beam(1'b0, beam_len(), 0, 0, 0, 0, 0);
                send_query($urandom_range(0, 1), 16'($urandom), 16'($urandom));
            end
            else
            begin
                sgr_in_t it;
                it = noise_item();
                if (it.mode == MODE_SCAN) it.last_beam = 1'b0;
                send_item(it);
            end
        end
        send_query(1'b1, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 0;
        sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty grid, then extremes of range and pose
        send_query(1'b1, 16'h0000, 16'h0000);
        send_beam(1'b0, 16'd0, 0, 0, 0, 0, 0);
        send_beam(1'b0, 16'd16383, 0, 0, 0, 0, 0);
        send_beam(1'b0, 16'd16384, 0, 0, 0, 0, 0);
        send_beam(1'b1, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'h0000, 16'h0000, 16'sh4000);
        for (int j = 0; j < 4; j++)
            send_query(j == 3, 16'h0000, 16'sh4000);
        // changed beam count, distant pose
        send_beam(1'b0, 16'd2000, 0, 0, 0, 0, 0);
        send_beam(1'b0, 16'd3000, 0, 0, 0, 0, 0);
        send_beam(1'b1, 16'd800, 16'sh8000, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 16'sh8000);
        // scan within the difference threshold is dropped
        send_beam(1'b0, 16'd2010, 0, 0, 0, 0, 0);
        send_beam(1'b0, 16'd3000, 0, 0, 0, 0, 0);
        send_beam(1'b1, 16'd800, 16'sd0, 16'sd0, 16'h1234, 16'h0000, 16'sd100);
        // partial scan abandoned by a query
        send_beam(1'b0, 16'd100, 0, 0, 0, 0, 0);
        send_beam(1'b0, 16'd200, 0, 0, 0, 0, 0);
        send_query(1'b0, 16'h8000, 16'sh7FFF);
        send_query(1'b1, 16'hC000, 16'sh8000);

        random_phase(110);
        configure(1, 65535, 0);
        random_phase(100);
        // one overlong scan: beams past the store are dropped
        for (int j = 0; j < 258; j++)
            send_beam(j == 257, 16'($urandom_range(0, 30000)), 16'sd500, -16'sd300,
                      16'h2000, 16'h0100, 16'sd256);
        // back to a short beam count
        random_scan(1'b1);
        send_query(1'b1, 16'h0000, 16'sd0);
        configure(15, 0, 65535);
        random_phase(60);
        configure(0, 4000, 300);
        random_phase(60);
        configure(3, 20000, 26);
        quiet = 1;
        random_phase(50);

        wait_drained();
        repeat (100) @(posedge clk);
        $display("Ran %0d transfers in, %0d results checked, %0d scans kept, five settings.",
                 sent, sb.checked, sb.kept);
        if (sb.errors == 0 && sb.expected_ranges.size() == 0)
            $display("[scan_grid_raycaster_unit] OK");
        else
            $display("[scan_grid_raycaster_unit] ERROR");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) sb.check(out_data);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #300_000_000;
        $display("[scan_grid_raycaster_unit] ERROR");
        $finish;
    end

endmodule
